>>> src/rpr_pkg.sv
package rpr_pkg;

  // Field widths of the request and result items
  localparam int COORD_BITS     = 32;
  localparam int INDEX_BITS     = 12;
  localparam int UNIT_BITS      = 16;
  localparam int UNIT_FRAC_DEF  = 14;
  localparam int CFG_INDEX_BITS = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_COS     = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIN     = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_X  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_Y  = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_Z  = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIVOT_X = 4'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIVOT_Y = 4'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIVOT_Z = 4'd7;

  // Register reset values (Q1.14 one for cos and axis z)
  localparam logic signed [UNIT_BITS-1:0] COS_RST    = 16'sd16384;
  localparam logic signed [UNIT_BITS-1:0] SIN_RST    = 16'sd0;
  localparam logic signed [UNIT_BITS-1:0] AXIS_X_RST = 16'sd0;
  localparam logic signed [UNIT_BITS-1:0] AXIS_Y_RST = 16'sd0;
  localparam logic signed [UNIT_BITS-1:0] AXIS_Z_RST = 16'sd16384;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic        [INDEX_BITS-1:0] point_index;
    logic                         last_point;
  } point_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rotated_x;
    logic signed [COORD_BITS-1:0] rotated_y;
    logic signed [COORD_BITS-1:0] rotated_z;
    logic        [INDEX_BITS-1:0] result_index;
    logic                         result_last;
    logic                         saturated;
  } point_rsp_t;

  // Pass-through fields carried alongside the pipeline
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  last;
  } side_t;

endpackage

>>> src/rodrigues_point_rotator_core.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    point_req_t (point x/y/z, index, last)
// out_      output     out_valid / out_ready  point_rsp_t (rotated x/y/z, index, last, sat)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Seven register stages; one request per cycle unless out_ready stalls. A request is
// registered in turn by the offset, product, cross/dot, sine, axis, sum and clip stages
// before it shows on out_valid. The depth is set by the two chained multiplies (dot
// product times one minus cos, then times the axis) with a rounding add between each.
// Synchronous active-low reset clears the stage valid bits and loads register reset
// values. Each stage holds only while it is full and the next one holds, so bubbles
// close up under a stall; cfg_ready is always high.
module rodrigues_point_rotator_core
  import rpr_pkg::*;
#(
  parameter int UNIT_FRAC_BITS = UNIT_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  point_req_t                in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output point_rsp_t                out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data
);

  localparam int NSTG  = 7;
  localparam int CW    = COORD_BITS;
  localparam int UW    = UNIT_BITS;
  localparam int F     = UNIT_FRAC_BITS;
  localparam int S_W   = CW + 1;
  localparam int P_W   = UW + S_W;
  localparam int CR_W  = P_W + 2;
  localparam int CRX_W = CR_W + 1;
  localparam int X_W   = CR_W - F + 1;
  localparam int OMC_W = (F + 2 > UW + 2) ? F + 2 : UW + 2;
  localparam int DM_W  = X_W + OMC_W;
  localparam int DMX_W = DM_W + 1;
  localparam int E_W   = DM_W - F + 1;
  localparam int CS_W  = UW + S_W;
  localparam int SX_W  = UW + X_W;
  localparam int EU_W  = UW + E_W;
  localparam int MX1_W = (CS_W > SX_W) ? CS_W : SX_W;
  localparam int MX_W  = (MX1_W > EU_W) ? MX1_W : EU_W;
  localparam int A_W   = MX_W + 1;
  localparam int T_W   = MX_W + 3;
  localparam int R_W   = T_W - F + 1;
  localparam int O_W   = R_W + 1;

  localparam logic signed [CRX_W-1:0] RND_CR = CRX_W'(1) <<< (F - 1);
  localparam logic signed [DMX_W-1:0] RND_DM = DMX_W'(1) <<< (F - 1);
  localparam logic signed [T_W-1:0]   RND_T  = T_W'(1) <<< (F - 1);
  localparam logic signed [OMC_W-1:0] ONE_F  = OMC_W'(1) <<< F;
  localparam logic signed [O_W-1:0]   O_MAX  = O_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [O_W-1:0]   O_MIN  = -O_MAX - O_W'(1);

  // Configuration registers
  logic signed [UW-1:0] cos_r, sin_r;
  logic signed [UW-1:0] u_r   [3];
  logic signed [CW-1:0] piv_r [3];

  // Pipeline control
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;
  side_t           side_r [NSTG];

  // Stage data
  logic signed [S_W-1:0]  s_r   [3];
  logic signed [P_W-1:0]  pr_r  [3][3];
  logic signed [CS_W-1:0] cs2_r [3];
  logic signed [X_W-1:0]  x_r   [3];
  logic signed [X_W-1:0]  d_r;
  logic signed [CS_W-1:0] cs3_r [3];
  logic signed [DM_W-1:0] dm_r;
  logic signed [SX_W-1:0] sx_r  [3];
  logic signed [CS_W-1:0] cs4_r [3];
  logic signed [A_W-1:0]  acc_r [3];
  logic signed [EU_W-1:0] eu_r  [3];
  logic signed [R_W-1:0]  r_r   [3];
  logic signed [CW-1:0]   rot_r [3];
  logic                   sat_r;

  // Combinational stage results
  logic signed [CRX_W-1:0] cr_sum [3];
  logic signed [CRX_W-1:0] dot_sum;
  logic signed [OMC_W-1:0] omc;
  logic signed [DMX_W-1:0] dm_rnd;
  logic signed [E_W-1:0]   e_val;
  logic signed [T_W-1:0]   t_sum  [3];
  logic signed [O_W-1:0]   o_sum  [3];
  logic signed [CW-1:0]    rot_nxt [3];
  logic                    sat_nxt;

  assign cfg_ready = 1'b1;

  // Decode configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r    <= COS_RST;
      sin_r    <= SIN_RST;
      u_r[0]   <= AXIS_X_RST;
      u_r[1]   <= AXIS_Y_RST;
      u_r[2]   <= AXIS_Z_RST;
      piv_r[0] <= '0;
      piv_r[1] <= '0;
      piv_r[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COS:     cos_r    <= cfg_data[UW-1:0];
        REG_SIN:     sin_r    <= cfg_data[UW-1:0];
        REG_AXIS_X:  u_r[0]   <= cfg_data[UW-1:0];
        REG_AXIS_Y:  u_r[1]   <= cfg_data[UW-1:0];
        REG_AXIS_Z:  u_r[2]   <= cfg_data[UW-1:0];
        REG_PIVOT_X: piv_r[0] <= cfg_data;
        REG_PIVOT_Y: piv_r[1] <= cfg_data;
        REG_PIVOT_Z: piv_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next stage advances
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_t'{index: in_data.point_index, last: in_data.last_point};
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Arithmetic between registers
  always_comb begin
    cr_sum[0] = pr_r[1][2] - pr_r[2][1] + RND_CR;
    cr_sum[1] = pr_r[2][0] - pr_r[0][2] + RND_CR;
    cr_sum[2] = pr_r[0][1] - pr_r[1][0] + RND_CR;
    dot_sum   = pr_r[0][0] + pr_r[1][1] + pr_r[2][2] + RND_CR;
    omc       = ONE_F - OMC_W'(cos_r);
    dm_rnd    = dm_r + RND_DM;
    e_val     = E_W'(dm_rnd >>> F);
    sat_nxt   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t_sum[i] = acc_r[i] + eu_r[i] + RND_T;
      o_sum[i] = O_W'(r_r[i]) + O_W'(piv_r[i]);
      if (o_sum[i] > O_MAX) begin
        rot_nxt[i] = CW'(O_MAX);
        sat_nxt    = 1'b1;
      end else if (o_sum[i] < O_MIN) begin
        rot_nxt[i] = CW'(O_MIN);
        sat_nxt    = 1'b1;
      end else begin
        rot_nxt[i] = CW'(o_sum[i]);
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    // offset from pivot
    if (en[0]) begin
      s_r[0] <= S_W'(in_data.point_x) - S_W'(piv_r[0]);
      s_r[1] <= S_W'(in_data.point_y) - S_W'(piv_r[1]);
      s_r[2] <= S_W'(in_data.point_z) - S_W'(piv_r[2]);
    end
    // axis-by-offset products and cos term
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[i][j] <= u_r[i] * s_r[j];
        end
        cs2_r[i] <= cos_r * s_r[i];
      end
    end
    // cross and dot products, rounded
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        x_r[i]   <= X_W'(cr_sum[i] >>> F);
        cs3_r[i] <= cs2_r[i];
      end
      d_r <= X_W'(dot_sum >>> F);
    end
    // sine term and dot times one minus cos
    if (en[3]) begin
      dm_r <= d_r * omc;
      for (int i = 0; i < 3; i++) begin
        sx_r[i]  <= sin_r * x_r[i];
        cs4_r[i] <= cs3_r[i];
      end
    end
    // axis term
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        eu_r[i]  <= e_val * u_r[i];
        acc_r[i] <= A_W'(cs4_r[i]) + A_W'(sx_r[i]);
      end
    end
    // sum and round
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        r_r[i] <= R_W'(t_sum[i] >>> F);
      end
    end
    // add pivot back and clip
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        rot_r[i] <= rot_nxt[i];
      end
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_data  = point_rsp_t'{
    rotated_x:    rot_r[0],
    rotated_y:    rot_r[1],
    rotated_z:    rot_r[2],
    result_index: side_r[NSTG-1].index,
    result_last:  side_r[NSTG-1].last,
    saturated:    sat_r
  };

`ifndef SYNTH
  // A full pipeline facing a stalled output takes no request
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ready) |-> !in_ready)
    else $error("request accepted into a full stalled pipeline");

  // Occupancy follows accepts and deliveries exactly
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v_r) == $past($countones(v_r))
                                 + $past(in_valid && in_ready)
                                 - $past(out_valid && out_ready)))
    else $error("pipeline occupancy lost or duplicated an item");

  // A clipped result holds at least one coordinate at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.rotated_x == CW'(O_MAX) || out_data.rotated_x == CW'(O_MIN) ||
       out_data.rotated_y == CW'(O_MAX) || out_data.rotated_y == CW'(O_MIN) ||
       out_data.rotated_z == CW'(O_MAX) || out_data.rotated_z == CW'(O_MIN)))
    else $error("saturated flag without a clipped coordinate");
`endif

endmodule

>>> sim/tb_rodrigues_point_rotator_core.sv
`timescale 1ns / 100ps

module tb_rodrigues_point_rotator_core;
  import rpr_pkg::*;

  localparam int FRAC        = UNIT_FRAC_DEF;
  localparam int LATENCY     = 7;
  localparam int REG_COUNT   = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [31:0] U_ONE  = 32'd16384;
  localparam logic [31:0] U_NEG  = 32'hFFFF_C000;
  localparam logic [31:0] C_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN  = 32'h8000_0000;
  localparam longint      COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint      COORD_LO = -COORD_HI - 1;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  point_req_t                in_data;
  logic                      out_valid;
  logic                      out_ready;
  point_rsp_t                out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]     cfg_data;

  // Register copies seen by the predictor
  logic signed [UNIT_BITS-1:0]  cos_q;
  logic signed [UNIT_BITS-1:0]  sin_q;
  logic signed [UNIT_BITS-1:0]  axis_q [3];
  logic signed [COORD_BITS-1:0] pivot_q [3];

  point_rsp_t pending_rotations [$];
  int         mismatch_count;
  int         cycle_count;
  int         src_idle_pct;
  int         sink_idle_pct;
  int         holds_asked;
  int         holds_done;

  rodrigues_point_rotator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[rodrigues_point_rotator_core] ERROR");
      $finish;
    end
  end

  function automatic longint round_q(longint v);
    return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // Rotate one point with the current register copies
  function automatic point_rsp_t rotate_point(point_req_t p);
    longint             c;
    longint             sn;
    longint             u [3];
    longint             pv [3];
    longint             s [3];
    longint             cr [3];
    longint             dot;
    longint             ep;
    longint             r;
    logic signed [31:0] pc [3];
    logic [31:0]        rot [3];
    bit                 clipped;
    point_rsp_t         rsp;
    pc = '{p.point_x, p.point_y, p.point_z};
    c = cos_q;
    sn = sin_q;
    clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      u[i] = axis_q[i];
      pv[i] = pivot_q[i];
      s[i] = longint'(pc[i]) - pv[i];
    end
    cr[0] = round_q(u[1] * s[2] - u[2] * s[1]);
    cr[1] = round_q(u[2] * s[0] - u[0] * s[2]);
    cr[2] = round_q(u[0] * s[1] - u[1] * s[0]);
    dot = round_q(u[0] * s[0] + u[1] * s[1] + u[2] * s[2]);
    ep = round_q(dot * ((longint'(1) <<< FRAC) - c));
    for (int i = 0; i < 3; i++) begin
      r = round_q(c * s[i] + sn * cr[i] + ep * u[i]) + pv[i];
      if (r > COORD_HI) begin
        r = COORD_HI;
        clipped = 1'b1;
      end else if (r < COORD_LO) begin
        r = COORD_LO;
        clipped = 1'b1;
      end
      rot[i] = r[31:0];
    end
    rsp.rotated_x    = rot[0];
    rsp.rotated_y    = rot[1];
    rsp.rotated_z    = rot[2];
    rsp.result_index = p.point_index;
    rsp.result_last  = p.last_point;
    rsp.saturated    = clipped;
    return rsp;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Track register writes, predict accepted requests, check results
  always @(posedge clk) begin
    point_rsp_t want;
    if (!rst_n) begin
      cos_q = COS_RST;
      sin_q = SIN_RST;
      axis_q = '{AXIS_X_RST, AXIS_Y_RST, AXIS_Z_RST};
      pivot_q = '{default: '0};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COS:     cos_q = cfg_data[UNIT_BITS-1:0];
          REG_SIN:     sin_q = cfg_data[UNIT_BITS-1:0];
          REG_AXIS_X:  axis_q[0] = cfg_data[UNIT_BITS-1:0];
          REG_AXIS_Y:  axis_q[1] = cfg_data[UNIT_BITS-1:0];
          REG_AXIS_Z:  axis_q[2] = cfg_data[UNIT_BITS-1:0];
          REG_PIVOT_X: pivot_q[0] = cfg_data;
          REG_PIVOT_Y: pivot_q[1] = cfg_data;
          REG_PIVOT_Z: pivot_q[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_rotations.push_back(rotate_point(in_data));
      if (out_valid && out_ready) begin
        if (pending_rotations.size() == 0) begin
          flag_mismatch("unexpected result, index", out_data.result_index, -1);
        end else begin
          want = pending_rotations.pop_front();
          if (out_data.rotated_x != want.rotated_x)
            flag_mismatch("rotated_x", out_data.rotated_x, want.rotated_x);
          if (out_data.rotated_y != want.rotated_y)
            flag_mismatch("rotated_y", out_data.rotated_y, want.rotated_y);
          if (out_data.rotated_z != want.rotated_z)
            flag_mismatch("rotated_z", out_data.rotated_z, want.rotated_z);
          if (out_data.result_index != want.result_index)
            flag_mismatch("result_index", out_data.result_index, want.result_index);
          if (out_data.result_last != want.result_last)
            flag_mismatch("result_last", out_data.result_last, want.result_last);
          if (out_data.saturated != want.saturated)
            flag_mismatch("saturated", out_data.saturated, want.saturated);
        end
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on demand
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_point(point_req_t p);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every pending result, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_rotation(logic [31:0] c, logic [31:0] sn, logic [31:0] ax,
                               logic [31:0] ay, logic [31:0] az, logic [31:0] px,
                               logic [31:0] py, logic [31:0] pz);
    drain();
    write_reg(REG_COS, c);
    write_reg(REG_SIN, sn);
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_PIVOT_X, px);
    write_reg(REG_PIVOT_Y, py);
    write_reg(REG_PIVOT_Z, pz);
  endtask

  function automatic point_req_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [INDEX_BITS-1:0] idx, logic last);
    point_req_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    p.point_index = idx;
    p.last_point = last;
    return p;
  endfunction

  function automatic logic [31:0] rand_unit();
    case ($urandom_range(15))
      0: return U_NEG;
      1: return U_ONE;
      2: return $urandom;
      default: return int'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return C_MAX;
      1: return C_MIN;
      2, 3: return $urandom;
      default: return int'($urandom_range(1 << 21)) - (1 << 20);
    endcase
  endfunction

  // Mostly points near the pivot, some anywhere, some at the range ends
  function automatic point_req_t random_point(logic [INDEX_BITS-1:0] idx, logic last);
    logic [31:0] c [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(9))
        0: c[i] = $urandom_range(1) ? C_MAX : C_MIN;
        1, 2: c[i] = $urandom;
        default: c[i] = pivot_q[i] + int'($urandom_range(1 << 22)) - (1 << 21);
      endcase
    end
    return make_point(c[0], c[1], c[2], idx, last);
  endfunction

  // Reset values give the identity rotation
  task automatic test_reset_identity();
    send_point(make_point(32'd0, 32'd0, 32'd0, 12'd0, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, 12'd1, 1'b0));
    send_point(make_point(C_MIN, C_MIN, C_MIN, 12'd2, 1'b0));
    send_point(make_point(32'd1, 32'hFFFF_FFFF, C_MAX, 12'hFFF, 1'b1));
  endtask

  task automatic test_directed_cases();
    // quarter turn about z around an offset pivot
    load_rotation(32'd0, U_ONE, 32'd0, 32'd0, U_ONE, 32'h0001_0000, 32'hFFFF_0000, 32'd0);
    send_point(make_point(32'h0002_0000, 32'd0, 32'h0005_0000, 12'd10, 1'b0));
    send_point(make_point(C_MAX, C_MIN, 32'd0, 12'd11, 1'b0));
    send_point(make_point(C_MIN, C_MAX, C_MAX, 12'd12, 1'b0));
    send_point(make_point(32'h0001_0000, 32'hFFFF_0000, 32'd7, 12'd13, 1'b1));
    // half turn about x with the pivot at the range ends
    load_rotation(U_NEG, 32'd0, U_ONE, 32'd0, 32'd0, C_MAX, C_MAX, C_MIN);
    send_point(make_point(C_MIN, C_MIN, C_MAX, 12'd20, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MIN, 12'd21, 1'b0));
    send_point(make_point(32'd0, 32'd0, 32'd0, 12'd22, 1'b1));
    // axis not unit length, cos and sin not consistent
    load_rotation(U_ONE, U_ONE, U_ONE, U_ONE, U_ONE, 32'd0, 32'd0, 32'd0);
    send_point(make_point(32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 12'd30, 1'b0));
    send_point(make_point(C_MAX, 32'd0, C_MIN, 12'd31, 1'b0));
    send_point(make_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 12'd32, 1'b1));
    // register values outside the stated range, upper data bits set
    load_rotation(32'hFFFF_8000, 32'h0001_7FFF, 32'h0000_8000, 32'h0000_7FFF,
                  32'hABCD_0001, $urandom, $urandom, $urandom);
    // writes beyond the register list must be dropped
    for (int k = REG_COUNT; k < (1 << CFG_INDEX_BITS); k++)
      write_reg(CFG_INDEX_BITS'(k), $urandom);
    send_point(make_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 12'd40, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, 12'd41, 1'b0));
    send_point(make_point(C_MIN, C_MIN, C_MIN, 12'd42, 1'b0));
    send_point(make_point($urandom, $urandom, $urandom, 12'd43, 1'b1));
  endtask

  // Point lists with running indexes and a closing last flag, plus stray points
  task automatic test_random_lists();
    int n;
    int len;
    int idx;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_rotation(U_NEG, U_NEG, U_NEG, U_NEG, U_NEG, C_MIN, C_MIN, C_MIN);
        1: load_rotation(U_ONE, U_ONE, U_ONE, U_ONE, U_ONE, C_MAX, C_MAX, C_MAX);
        default: load_rotation(rand_unit(), rand_unit(), rand_unit(), rand_unit(),
                               rand_unit(), rand_coord(), rand_coord(), rand_coord());
      endcase
      n = 0;
      while (n < 110) begin
        if ($urandom_range(9) == 0) begin
          send_point(random_point(INDEX_BITS'($urandom), 1'($urandom)));
          n++;
        end else begin
          len = $urandom_range(24, 1);
          idx = $urandom_range(4095);
          for (int k = 0; k < len; k++)
            send_point(random_point(INDEX_BITS'(idx + k), k == len - 1));
          n += len;
        end
      end
    end
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    load_rotation(rand_unit(), rand_unit(), rand_unit(), rand_unit(), rand_unit(),
                  rand_coord(), rand_coord(), rand_coord());
    src_idle_pct = 0;
    sink_idle_pct = 0;
    for (int k = 0; k < 100; k++)
      send_point(random_point(INDEX_BITS'(k), k == 99));
    drain();
    src_idle_pct = 25;
    sink_idle_pct = 25;
  endtask

  // Hold the result side off so the pipe fills and stalls its input
  task automatic test_output_stall();
    load_rotation(rand_unit(), rand_unit(), rand_unit(), rand_unit(), rand_unit(),
                  rand_coord(), rand_coord(), rand_coord());
    holds_asked++;
    for (int k = 0; k < 60; k++)
      send_point(random_point(INDEX_BITS'($urandom), 1'($urandom)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    src_idle_pct = 25;
    sink_idle_pct = 25;
    holds_asked = 0;
    holds_done = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_identity();
    test_directed_cases();
    test_random_lists();
    test_back_to_back();
    test_output_stall();
    drain();

    if (mismatch_count == 0 && pending_rotations.size() == 0)
      $display("[rodrigues_point_rotator_core] OK");
    else
      $display("[rodrigues_point_rotator_core] ERROR");
    $finish;
  end

endmodule

>>> sim.f
src/rpr_pkg.sv
src/rodrigues_point_rotator_core.sv
sim/tb_rodrigues_point_rotator_core.sv
